@@ rtl/core/pfa_pkg.sv @@
`timescale 1ns / 1ps

package pfa_pkg;

	localparam int VIRT_PAGES      = 4096;
	localparam int PHYS_PAGES      = 1024;
	localparam int PAGE_SHIFT      = 16;
	localparam int MAX_BATCH_PAGES = 32;

	localparam int ADDR_W   = 40;
	localparam int SIZE_W   = 22;
	localparam int ALOG_W   = 6;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;

	localparam int VIDX_W  = $clog2(VIRT_PAGES);
	localparam int PID_W   = $clog2(PHYS_PAGES);
	localparam int CNT_W   = $clog2(PHYS_PAGES + 1);
	localparam int PTE_W   = PID_W + 1;
	localparam int BATCH_W = $clog2(MAX_BATCH_PAGES + 1);
	localparam int BIDX_W  = (MAX_BATCH_PAGES > 1) ? $clog2(MAX_BATCH_PAGES) : 1;
	localparam int CPG_W   = SIZE_W + 1 - PAGE_SHIFT;
	localparam int UPG_W   = SIZE_W - PAGE_SHIFT;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = ADDR_W;

	localparam logic [CNT_W-1:0] BUDGET_RESET = CNT_W'(PHYS_PAGES);

	localparam logic [KIND_W-1:0] KIND_COMMIT   = KIND_W'(0);
	localparam logic [KIND_W-1:0] KIND_DECOMMIT = KIND_W'(1);
	localparam logic [KIND_W-1:0] KIND_RELEASE  = KIND_W'(2);

	localparam logic [CFG_IDX_W-1:0] REG_VBASE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PBASE  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_BUDGET = CFG_IDX_W'(2);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_RANGE,
		ST_NOMEM,
		ST_TOO_LARGE,
		ST_UNMAPPED
	} status_t;

	typedef struct packed {
		logic                commit;
		logic                strict;
		status_t             status;
		logic [ADDR_W-1:0]   va;
		logic [VIDX_W-1:0]   first;
		logic [BATCH_W-1:0]  pages;
	} cmd_t;

	typedef struct packed {
		status_t             status;
		logic [ADDR_W-1:0]   va;
		logic [ADDR_W-1:0]   pa;
		logic                changed;
		logic [CNT_W-1:0]    free_pages;
		logic                last;
	} res_t;

endpackage

@@ rtl/core/page_frame_allocator_top.sv @@
`timescale 1ns / 1ps

// Page frame allocator: maps virtual pages of a fixed window onto pages
// popped from a stack of free physical pages, and unmaps them again.
// Input queue side: an item (kind, address, size_bytes, align_log2) transfers
// on a clock edge with push high and full low. Result side: while empty is
// low the oldest result is on the result ports; it transfers on pop high.
// Each request of a known kind gives one result per page walked, or one
// result when it is rejected or empty; last marks the final result of a
// request. Items of an unknown kind are dropped and give no result.
// The front checks each item in stage A, then stage B. The back unit pops
// a command and starts it, then per page reads the table and stack and then
// updates them, through its single table/stack port pair; it takes the next
// command only once the current one is done. The front accepts and checks
// the following items meanwhile through a two-entry command queue.
// Reset, and every write of page_budget, starts a clearing pass over the
// whole page table (the stack is rebuilt in the same pass) during which
// full stays high. Configuration writes go through cfg_write at any time
// the block is idle. A stalled receiver fills the two-entry result queue,
// then the back halts and full rises once the command queue and front fill.
module page_frame_allocator_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pfa_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             push,
	output logic                             full,
	input  logic [pfa_pkg::KIND_W-1:0]       kind,
	input  logic [pfa_pkg::ADDR_W-1:0]       address,
	input  logic [pfa_pkg::SIZE_W-1:0]       size_bytes,
	input  logic [pfa_pkg::ALOG_W-1:0]       align_log2,
	output logic                             empty,
	input  logic                             pop,
	output logic [pfa_pkg::STATUS_W-1:0]     status,
	output logic [pfa_pkg::ADDR_W-1:0]       virt_addr,
	output logic [pfa_pkg::ADDR_W-1:0]       phys_addr,
	output logic                             changed,
	output logic [pfa_pkg::CNT_W-1:0]        free_pages,
	output logic                             last
);
	import pfa_pkg::*;

	logic [ADDR_W-1:0] vbase_q, pbase_q;
	logic [CNT_W-1:0]  budget_q;
	logic [CNT_W-1:0]  budget_wr;
	logic              clear_req, clearing;

	cmd_t   front_cmd, queue_cmd;
	logic   cmd_push, cmd_full, cmd_empty, cmd_pop;
	res_t   back_res, head_res;
	logic   res_push, res_full;

	assign clear_req = cfg_write && (cfg_index == REG_BUDGET);
	assign budget_wr = (cfg_data[CNT_W-1:0] > CNT_W'(PHYS_PAGES)) ?
	                   CNT_W'(PHYS_PAGES) : cfg_data[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbase_q  <= '0;
			pbase_q  <= '0;
			budget_q <= BUDGET_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_VBASE:  vbase_q  <= cfg_data[ADDR_W-1:0];
				REG_PBASE:  pbase_q  <= cfg_data[ADDR_W-1:0];
				REG_BUDGET: budget_q <= budget_wr;
				default: begin
				end
			endcase
		end
	end

	pfa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.hold       (clearing),
		.kind       (kind),
		.address    (address),
		.size_bytes (size_bytes),
		.align_log2 (align_log2),
		.vbase      (vbase_q),
		.cmd        (front_cmd),
		.cmd_push   (cmd_push),
		.cmd_full   (cmd_full)
	);

	pfa_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.full   (cmd_full),
		.wdata  (front_cmd),
		.pop    (cmd_pop),
		.empty  (cmd_empty),
		.rdata  (queue_cmd)
	);

	pfa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear_req (clear_req),
		.budget    (budget_q),
		.pbase     (pbase_q),
		.clearing  (clearing),
		.cmd_empty (cmd_empty),
		.cmd       (queue_cmd),
		.cmd_pop   (cmd_pop),
		.res       (back_res),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	pfa_res_queue u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (back_res),
		.pop    (pop),
		.empty  (empty),
		.rdata  (head_res)
	);

	assign status     = head_res.status;
	assign virt_addr  = head_res.va;
	assign phys_addr  = head_res.pa;
	assign changed    = head_res.changed;
	assign free_pages = head_res.free_pages;
	assign last       = head_res.last;

endmodule

@@ rtl/core/pfa_front.sv @@
`timescale 1ns / 1ps

module pfa_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          hold,
	input  logic [pfa_pkg::KIND_W-1:0]    kind,
	input  logic [pfa_pkg::ADDR_W-1:0]    address,
	input  logic [pfa_pkg::SIZE_W-1:0]    size_bytes,
	input  logic [pfa_pkg::ALOG_W-1:0]    align_log2,
	input  logic [pfa_pkg::ADDR_W-1:0]    vbase,
	output pfa_pkg::cmd_t                 cmd,
	output logic                          cmd_push,
	input  logic                          cmd_full
);
	import pfa_pkg::*;

	logic                 s1_v_q;
	logic [KIND_W-1:0]    kind_s1;
	logic [ADDR_W-1:0]    addr_s1;
	logic [SIZE_W-1:0]    size_s1;
	logic [ALOG_W-1:0]    alog_s1;

	logic                 s2_v_q;
	logic [KIND_W-1:0]    kind_s2;
	logic [ADDR_W:0]      va_s2;
	logic [CPG_W-1:0]     cpages_s2;
	logic [UPG_W-1:0]     upages_s2;

	logic [ALOG_W-1:0]    sh;
	logic [ADDR_W:0]      mask;
	logic [ADDR_W:0]      aligned;
	logic [SIZE_W:0]      size_up;
	logic [CPG_W-1:0]     cpages;

	logic                 known;
	logic                 s2_go, s2_take, s1_go, accept;

	logic                 lt;
	logic [ADDR_W:0]      diff;
	logic [ADDR_W+1:0]    blk_end, win_end;
	logic [ADDR_W+1-PAGE_SHIFT:0] upg_end;
	logic                 range_bad, too_big;

	// stage A: align up and round the size
	always_comb begin
		sh = alog_s1;
		if (alog_s1 < ALOG_W'(PAGE_SHIFT))
			sh = ALOG_W'(PAGE_SHIFT);
		else if (alog_s1 > ALOG_W'(ADDR_W))
			sh = ALOG_W'(ADDR_W);
		mask    = ((ADDR_W+1)'(1) << sh) - (ADDR_W+1)'(1);
		aligned = ({1'b0, addr_s1} + mask) & ~mask;
		size_up = {1'b0, size_s1} + (SIZE_W+1)'((1 << PAGE_SHIFT) - 1);
		cpages  = size_up[SIZE_W:PAGE_SHIFT];
	end

	// stage B: range and batch checks
	always_comb begin
		lt      = va_s2 < {1'b0, vbase};
		diff    = va_s2 - {1'b0, vbase};
		blk_end = {1'b0, va_s2} + ((ADDR_W+2)'(cpages_s2) << PAGE_SHIFT);
		win_end = {2'b00, vbase} + ((ADDR_W+2)'(VIRT_PAGES) << PAGE_SHIFT);
		upg_end = {1'b0, diff[ADDR_W:PAGE_SHIFT]} + (ADDR_W+2-PAGE_SHIFT)'(upages_s2);
		if (kind_s2 == KIND_COMMIT) begin
			range_bad = lt || (blk_end > win_end);
			too_big   = cpages_s2 > CPG_W'(MAX_BATCH_PAGES);
		end else begin
			range_bad = lt || (upg_end > (ADDR_W+2-PAGE_SHIFT)'(VIRT_PAGES));
			too_big   = upages_s2 > UPG_W'(MAX_BATCH_PAGES);
		end
		cmd.commit = kind_s2 == KIND_COMMIT;
		cmd.strict = kind_s2 == KIND_DECOMMIT;
		if (range_bad)
			cmd.status = ST_RANGE;
		else if (too_big)
			cmd.status = ST_TOO_LARGE;
		else
			cmd.status = ST_OK;
		cmd.va    = va_s2[ADDR_W-1:0];
		cmd.first = diff[PAGE_SHIFT+VIDX_W-1:PAGE_SHIFT];
		cmd.pages = (kind_s2 == KIND_COMMIT) ? cpages_s2[BATCH_W-1:0]
		                                     : BATCH_W'(upages_s2);
	end

	assign known    = (kind_s2 == KIND_COMMIT) || (kind_s2 == KIND_DECOMMIT) ||
	                  (kind_s2 == KIND_RELEASE);
	// unknown kinds drop here without a transfer
	assign s2_go    = s2_v_q && (!cmd_full || !known);
	assign cmd_push = s2_v_q && known && !cmd_full;
	assign s2_take  = !s2_v_q || s2_go;
	assign s1_go    = s1_v_q && s2_take;
	assign full     = hold || (s1_v_q && !s1_go);
	assign accept   = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (accept)
				s1_v_q <= 1'b1;
			else if (s1_go)
				s1_v_q <= 1'b0;
			if (s1_go)
				s2_v_q <= 1'b1;
			else if (s2_go)
				s2_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			addr_s1 <= address;
			size_s1 <= size_bytes;
			alog_s1 <= align_log2;
		end
		if (s1_go) begin
			kind_s2   <= kind_s1;
			va_s2     <= (kind_s1 == KIND_COMMIT) ? aligned : {1'b0, addr_s1};
			cpages_s2 <= cpages;
			upages_s2 <= size_s1[SIZE_W-1:PAGE_SHIFT];
		end
	end

endmodule

@@ rtl/core/pfa_cmd_queue.sv @@
`timescale 1ns / 1ps

module pfa_cmd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  pfa_pkg::cmd_t   wdata,
	input  logic            pop,
	output logic            empty,
	output pfa_pkg::cmd_t   rdata
);
	import pfa_pkg::*;

	cmd_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr)
				wp_q <= !wp_q;
			if (do_rd)
				rp_q <= !rp_q;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wp_q] <= wdata;
	end

endmodule

@@ rtl/core/pfa_res_queue.sv @@
`timescale 1ns / 1ps

module pfa_res_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  pfa_pkg::res_t   wdata,
	input  logic            pop,
	output logic            empty,
	output pfa_pkg::res_t   rdata
);
	import pfa_pkg::*;

	res_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr)
				wp_q <= !wp_q;
			if (do_rd)
				rp_q <= !rp_q;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wp_q] <= wdata;
	end

endmodule

@@ rtl/core/pfa_back.sv @@
`timescale 1ns / 1ps

module pfa_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear_req,
	input  logic [pfa_pkg::CNT_W-1:0]     budget,
	input  logic [pfa_pkg::ADDR_W-1:0]    pbase,
	output logic                          clearing,
	input  logic                          cmd_empty,
	input  pfa_pkg::cmd_t                 cmd,
	output logic                          cmd_pop,
	output pfa_pkg::res_t                 res,
	output logic                          res_push,
	input  logic                          res_full
);
	import pfa_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_LOOKUP,
		S_UPDATE
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [BIDX_W-1:0]   i_q;
	logic [CNT_W-1:0]    fc_q;
	logic [VIDX_W-1:0]   clr_q;

	logic [PTE_W-1:0]    pt_mem [VIRT_PAGES];
	logic [PID_W-1:0]    fs_mem [PHYS_PAGES];
	logic [PTE_W-1:0]    pt_rd_q;
	logic [PID_W-1:0]    fs_rd_q;

	logic                pt_we, fs_we;
	logic [VIDX_W-1:0]   pt_wa, pt_ra;
	logic [PTE_W-1:0]    pt_wd;
	logic [PID_W-1:0]    fs_wa, fs_ra, fs_wd;
	logic [CNT_W-1:0]    fc_nxt;

	logic                pte_valid;
	logic [PID_W-1:0]    pte_id;
	logic                short_nomem, single, last_page;
	logic [ADDR_W-1:0]   page_va;

	function automatic logic [ADDR_W-1:0] phys_of(input logic [ADDR_W-1:0] base,
	                                              input logic [PID_W-1:0] id);
		return base + (ADDR_W'(id) << PAGE_SHIFT);
	endfunction

	assign clearing  = state_q == S_CLEAR;
	assign cmd_pop   = (state_q == S_IDLE) && !cmd_empty;
	assign pte_valid = pt_rd_q[PID_W];
	assign pte_id    = pt_rd_q[PID_W-1:0];
	assign pt_ra     = cmd_q.first + VIDX_W'(i_q);
	assign fs_ra     = PID_W'(fc_q - CNT_W'(1));
	assign page_va   = cmd_q.va + (ADDR_W'(i_q) << PAGE_SHIFT);
	assign last_page = BATCH_W'(i_q) == (cmd_q.pages - BATCH_W'(1));
	assign short_nomem = cmd_q.commit && (CNT_W'(cmd_q.pages) > fc_q);
	assign single    = (cmd_q.status != ST_OK) || (cmd_q.pages == '0) || short_nomem;

	always_comb begin
		res_push       = 1'b0;
		res.status     = ST_OK;
		res.va         = page_va;
		res.pa         = '0;
		res.changed    = 1'b0;
		res.free_pages = fc_q;
		res.last       = last_page;
		pt_we  = 1'b0;
		pt_wa  = pt_ra;
		pt_wd  = '0;
		fs_we  = 1'b0;
		fs_wa  = PID_W'(fc_q);
		fs_wd  = pte_id;
		fc_nxt = fc_q;
		case (state_q)
			S_CLEAR: begin
				// wipe the table and rebuild the stack so that page 0 sits on top
				pt_we = 1'b1;
				pt_wa = clr_q;
				fs_we = int'(clr_q) < PHYS_PAGES;
				fs_wa = PID_W'(clr_q);
				fs_wd = ({1'b0, clr_q} < (VIDX_W+1)'(budget)) ?
				        PID_W'(budget) - PID_W'(1) - PID_W'(clr_q) : '0;
			end
			S_START: begin
				res.va   = cmd_q.va;
				res.last = 1'b1;
				if (cmd_q.status != ST_OK)
					res.status = cmd_q.status;
				else if (short_nomem)
					res.status = ST_NOMEM;
				res_push = single && !res_full;
			end
			S_UPDATE: begin
				if (!res_full) begin
					res_push = 1'b1;
					if (cmd_q.commit) begin
						if (pte_valid) begin
							res.pa = phys_of(pbase, pte_id);
						end else if (fc_q == '0) begin
							res.status = ST_NOMEM;
						end else begin
							fc_nxt      = fc_q - CNT_W'(1);
							pt_we       = 1'b1;
							pt_wd       = {1'b1, fs_rd_q};
							res.pa      = phys_of(pbase, fs_rd_q);
							res.changed = 1'b1;
						end
					end else begin
						if (pte_valid) begin
							pt_we = 1'b1;
							if (fc_q < CNT_W'(PHYS_PAGES)) begin
								fs_we  = 1'b1;
								fc_nxt = fc_q + CNT_W'(1);
							end
							res.pa      = phys_of(pbase, pte_id);
							res.changed = 1'b1;
						end else if (cmd_q.strict) begin
							res.status = ST_UNMAPPED;
						end
					end
					res.free_pages = fc_nxt;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pt_we)
			pt_mem[pt_wa] <= pt_wd;
		pt_rd_q <= pt_mem[pt_ra];
	end

	always_ff @(posedge clk) begin
		if (fs_we)
			fs_mem[fs_wa] <= fs_wd;
		fs_rd_q <= fs_mem[fs_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			fc_q    <= '0;
			i_q     <= '0;
		end else if (clear_req) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + VIDX_W'(1);
					if (clr_q == VIDX_W'(VIRT_PAGES - 1)) begin
						fc_q    <= budget;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!cmd_empty)
						state_q <= S_START;
				end
				S_START: begin
					i_q <= '0;
					if (!single)
						state_q <= S_LOOKUP;
					else if (!res_full)
						state_q <= S_IDLE;
				end
				S_LOOKUP: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (!res_full) begin
						fc_q <= fc_nxt;
						if (last_page) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + BIDX_W'(1);
							state_q <= S_LOOKUP;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop)
			cmd_q <= cmd;
	end

	a_fc_within_budget: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |-> (fc_q <= budget))
		else $error("free count above page budget");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result transfer into a full queue");

	a_last_ends_request: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.last && !clear_req) |=> (state_q == S_IDLE))
		else $error("request continued after its final result");

endmodule
